// File: src/vsm_pkg.sv
package vsm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_WORDS_DEF = 65536;
    localparam int GEN_BITS_DEF     = 8;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_ONCE = 2'd1;
    localparam logic [1:0] MODE_LOOP = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_STALE   = 2'd2;

    localparam logic [16:0] MAX_LENGTH = 17'h10000;
    localparam logic signed [15:0] MIX_MAX = 16'sh7FFF;
    localparam logic signed [15:0] MIX_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_value;
        logic [16:0]        asset_length;
        logic               loop_mode;
        logic [3:0]         voice_select;
        logic [7:0]         ref_generation;
    } vsm_in_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic [3:0]         voice_granted;
        logic [7:0]         granted_generation;
        logic [1:0]         status;
    } vsm_out_t;

endpackage

// File: src/voice_sample_mixer_unit.sv
// Multi-voice sample playback mixer.
// Input channel (in_valid/in_stall/in_data) carries one request per transfer:
// write a sample word, start a voice, stop a voice, or tick one output sample.
// Every request yields exactly one result on out_valid/out_stall/out_data.
// Voice state (mode, base, length, cursor, generation) lives in a register
// file of VOICES entries; samples live in a SAMPLE_WORDS synchronous RAM.
// Steps: write and stop go straight to the finish step, start walks the slots
// until the first free one, and tick walks every voice with one sample RAM
// read for each voice that is playing.
// The sample RAM read port sets the tick rate: one voice per cycle.
// One request is in work at a time; in_stall is high while a request is in
// work. A finished result waits in the output register while the next
// request proceeds; the finish step holds until that register is free.
// Reset frees every voice and zeroes generations; the sample RAM is not
// cleared, and reading a never-written word returns arbitrary data.
// While out_stall is high the result holds in the output register.
module voice_sample_mixer_unit
    import vsm_pkg::*;
#(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    parameter int GEN_BITS     = GEN_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  vsm_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output vsm_out_t out_data
);

    localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AB = $clog2(SAMPLE_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_START, S_TICK, S_DRAIN, S_OUT} state_t;

    state_t state_reg;
    logic [1:0]          mode_reg   [VOICES];
    logic [15:0]         base_reg   [VOICES];
    logic [16:0]         len_reg    [VOICES];
    logic [15:0]         cur_reg    [VOICES];
    logic [GEN_BITS-1:0] gen_reg    [VOICES];

    vsm_in_t  req_reg;
    vsm_out_t wrk_reg;
    vsm_out_t res_reg;
    logic     res_valid_reg;
    logic [VB:0] idx_reg;
    logic        rd_pend_reg;
    logic signed [31:0] acc_reg;

    logic [VB-1:0] vi;
    logic [VB-1:0] sel;
    logic          accept;
    logic          stop_hit;
    logic          out_load;
    logic signed [15:0] sat_sample;
    logic          ram_we;
    logic [AB-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_rdata;
    logic [16:0]   sum_addr;

    assign vi        = idx_reg[VB-1:0];
    assign sel       = VB'(in_data.voice_select);
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign out_load  = (state_reg == S_OUT) && (!res_valid_reg || !out_stall);
    assign stop_hit  = (32'(in_data.voice_select) < VOICES)
                       && (gen_reg[sel] == GEN_BITS'(in_data.ref_generation))
                       && (mode_reg[sel] == MODE_ONCE || mode_reg[sel] == MODE_LOOP);
    assign sat_sample = (acc_reg > 32'(MIX_MAX)) ? MIX_MAX
                      : (acc_reg < 32'(MIX_MIN)) ? MIX_MIN : acc_reg[15:0];
    assign ram_we    = accept && (in_data.action == ACT_WRITE);
    assign ram_waddr = AB'(in_data.sample_address);
    assign sum_addr  = {1'b0, base_reg[vi]} + {1'b0, cur_reg[vi]};
    assign ram_raddr = AB'(sum_addr);

    vsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_samples (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data.sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                mode_reg[i] <= MODE_FREE;
                base_reg[i] <= '0;
                len_reg[i]  <= '0;
                cur_reg[i]  <= '0;
                gen_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            rd_pend_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= in_data;
                        wrk_reg.mixed_sample       <= '0;
                        wrk_reg.voice_granted      <= '0;
                        wrk_reg.granted_generation <= '0;
                        wrk_reg.status <= (in_data.action == ACT_STOP && !stop_hit)
                                          ? ST_STALE : ST_DONE;
                        idx_reg <= '0;
                        acc_reg <= '0;
                        case (in_data.action)
                            ACT_WRITE: state_reg <= S_OUT;
                            ACT_START: state_reg <= S_START;
                            ACT_TICK:  state_reg <= S_TICK;
                            default:
                            begin
                                state_reg <= S_OUT;
                                if (stop_hit)
                                begin
                                    mode_reg[sel] <= MODE_STOP;
                                end
                            end
                        endcase
                    end
                end
                S_START:
                begin
                    if (32'(idx_reg) >= VOICES)
                    begin
                        wrk_reg.status <= ST_NO_FREE;
                        state_reg      <= S_OUT;
                    end
                    else if (mode_reg[vi] == MODE_FREE)
                    begin
                        base_reg[vi] <= req_reg.sample_address;
                        len_reg[vi]  <= (req_reg.asset_length > MAX_LENGTH)
                                        ? MAX_LENGTH : req_reg.asset_length;
                        cur_reg[vi]  <= '0;
                        mode_reg[vi] <= req_reg.loop_mode ? MODE_LOOP : MODE_ONCE;
                        wrk_reg.voice_granted      <= 4'(idx_reg);
                        wrk_reg.granted_generation <= 8'(gen_reg[vi]);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TICK, S_DRAIN:
                begin
                    // add the word read for the previous voice
                    if (rd_pend_reg)
                    begin
                        acc_reg <= acc_reg + 32'(signed'(ram_rdata));
                    end
                    if (state_reg == S_DRAIN)
                    begin
                        wrk_reg.mixed_sample <= sat_sample;
                        state_reg <= S_OUT;
                    end
                    else if (32'(idx_reg) >= VOICES)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        case (mode_reg[vi])
                            MODE_LOOP:
                            begin
                                if (len_reg[vi] == '0)
                                begin
                                    mode_reg[vi] <= MODE_FREE;
                                    base_reg[vi] <= '0;
                                    len_reg[vi]  <= '0;
                                    cur_reg[vi]  <= '0;
                                    gen_reg[vi]  <= gen_reg[vi] + 1'b1;
                                end
                                else
                                begin
                                    rd_pend_reg <= 1'b1;
                                    if (17'(cur_reg[vi]) + 17'd1 >= len_reg[vi])
                                        cur_reg[vi] <= '0;
                                    else
                                        cur_reg[vi] <= cur_reg[vi] + 16'd1;
                                end
                            end
                            MODE_ONCE:
                            begin
                                if (17'(cur_reg[vi]) < len_reg[vi])
                                begin
                                    rd_pend_reg <= 1'b1;
                                end
                                if (17'(cur_reg[vi]) + 17'd1 >= len_reg[vi])
                                begin
                                    mode_reg[vi] <= MODE_FREE;
                                    base_reg[vi] <= '0;
                                    len_reg[vi]  <= '0;
                                    cur_reg[vi]  <= '0;
                                    gen_reg[vi]  <= gen_reg[vi] + 1'b1;
                                end
                                else
                                begin
                                    cur_reg[vi] <= cur_reg[vi] + 16'd1;
                                end
                            end
                            MODE_STOP:
                            begin
                                mode_reg[vi] <= MODE_FREE;
                                base_reg[vi] <= '0;
                                len_reg[vi]  <= '0;
                                cur_reg[vi]  <= '0;
                                gen_reg[vi]  <= gen_reg[vi] + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        res_reg   <= wrk_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept) else $error("accept while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without finish");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_stall) |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

// File: src/vsm_ram.sv
module vsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
